// File: sv/mbet_pkg.sv
// shared constants and types of the mandelbrot escape-time core
// no dependencies; every other file of the block uses it
package mbet_pkg;

  localparam int DEF_GRID_SIZE  = 64;
  localparam int DEF_MAX_ITER   = 256;
  localparam int DEF_FRAC_BITS  = 28;

  localparam int COORD_W        = 32;
  localparam int ZOOM_W         = 5;
  localparam int COUNT_W        = 9;
  localparam int CFG_IDX_W      = 2;

  localparam logic [ZOOM_W-1:0] DEF_ZOOM_SHIFT = ZOOM_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_REAL = 2'd0,
    REG_CENTER_IMAG = 2'd1,
    REG_ZOOM_SHIFT  = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_UPDATE,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SEL_RI,
    SEL_RR,
    SEL_II
  } sel_e;

endpackage

// File: sv/mbet_cfg_if.sv
// configuration write channel of the mandelbrot escape-time core
// depends on mbet_pkg for the index and data widths
interface mbet_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mbet_pkg::CFG_IDX_W-1:0]  index;
  logic [mbet_pkg::COORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/mbet_pixel_if.sv
// pixel request channel: column and row index of one grid point
// depends on mbet_pkg for the default grid size
interface mbet_pixel_if #(
  parameter int IDX_W = $clog2(mbet_pkg::DEF_GRID_SIZE)
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] col_index;
  logic [IDX_W-1:0] row_index;

  modport source (output valid, output col_index, output row_index, input ready);
  modport sink   (input valid, input col_index, input row_index, output ready);
endinterface

// File: sv/mbet_result_if.sv
// result channel: escape count and in-set flag of one pixel
// depends on mbet_pkg for the count width
interface mbet_result_if;
  logic                          valid;
  logic                          ready;
  logic [mbet_pkg::COUNT_W-1:0]  escape_count;
  logic                          in_set;

  modport source (output valid, output escape_count, output in_set, input ready);
  modport sink   (input valid, input escape_count, input in_set, output ready);
endinterface

// File: sv/mbet_mul.sv
// iterative signed fixed-point multiplier, one operand chunk per cycle
// floor rounding and saturation to Q8.FRAC_BITS; depends on mbet_pkg
module mbet_mul #(
  parameter int FRAC_BITS = mbet_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [FRAC_BITS+7:0]  a_i,
  input  logic signed [FRAC_BITS+7:0]  b_i,
  output logic                         done_o,
  output logic signed [FRAC_BITS+7:0]  p_o
);

  localparam int QW   = FRAC_BITS + 8;
  localparam int CH   = 18;
  localparam int NCH  = (QW + CH - 1) / CH;
  localparam int BW   = NCH * CH;
  localparam int AW   = QW + BW;
  localparam int RW   = AW - FRAC_BITS;
  localparam int CNTW = $clog2(NCH + 1);

  localparam logic [RW-1:0] NEG_LIM = RW'(1) << (QW - 1);
  localparam logic [RW-1:0] POS_LIM = (RW'(1) << (QW - 1)) - RW'(1);
  localparam logic [QW-1:0] QMAX    = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] QMIN    = {1'b1, {(QW-1){1'b0}}};

  logic [QW-1:0]   ua_q;
  logic [BW-1:0]   ub_q;
  logic [AW-1:0]   acc_q;
  logic            neg_q;
  logic [CNTW-1:0] cnt_q;
  logic            fin_q;
  logic            done_q;
  logic [QW-1:0]   p_q;

  logic [QW+CH-1:0] prod;
  logic [AW-1:0]    acc_step;
  logic [RW-1:0]    quo;
  logic             rnd;
  logic [RW-1:0]    quo_r;
  logic [QW-1:0]    p_d;

  always_comb begin
    prod     = ua_q * ub_q[BW-1 -: CH];
    acc_step = (acc_q << CH) + AW'(prod);
    quo      = acc_q[AW-1:FRAC_BITS];
    rnd      = neg_q & (|acc_q[FRAC_BITS-1:0]);
    quo_r    = quo + RW'(rnd);
    if (neg_q) begin
      p_d = (quo_r > NEG_LIM) ? QMIN : QW'(-quo_r);
    end else begin
      p_d = (quo_r > POS_LIM) ? QMAX : quo_r[QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        cnt_q <= CNTW'(NCH);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNTW'(1);
        fin_q <= (cnt_q == CNTW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= a_i[QW-1] ? QW'(-a_i) : QW'(a_i);
      ub_q  <= BW'(b_i[QW-1] ? QW'(-b_i) : QW'(b_i));
      neg_q <= a_i[QW-1] ^ b_i[QW-1];
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= acc_step;
      ub_q  <= ub_q << CH;
    end
    if (fin_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = $signed(p_q);

endmodule

// File: sv/mandelbrot_escape_time_core.sv
// Escape-time core for one pixel of a GRID_SIZE square view of the Mandelbrot set. A pixel
// request maps its column and row to c = center + offset * 2^-zoom_shift and iterates
// z = z^2 + c in saturating Q8.FRAC_BITS until |z|^2 exceeds 4 or MAX_ITER is reached.
// All products go through one shared iterative multiplier that takes one 18-bit chunk of an
// operand per cycle, in NCH = ceil((FRAC_BITS+8)/18) chunks per product. Each iteration needs
// three products plus an update and a check. The core takes one pixel at a time; a finished
// result waits in an output register so the next pixel can start while it is pending.
module mandelbrot_escape_time_core #(
  parameter int GRID_SIZE = mbet_pkg::DEF_GRID_SIZE,
  parameter int MAX_ITER  = mbet_pkg::DEF_MAX_ITER,
  parameter int FRAC_BITS = mbet_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mbet_cfg_if.sink             cfg_i,
  mbet_pixel_if.sink           pixel_i,
  mbet_result_if.source        result_o
);

  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam int HALF  = GRID_SIZE / 2;
  localparam int QW    = FRAC_BITS + 8;
  localparam int CNT_W = $clog2(MAX_ITER + 1);
  localparam int SHW   = $clog2(FRAC_BITS + 32);
  localparam int SUM_A = IDX_W + FRAC_BITS + 3;
  localparam int SUM_B = (SUM_A > 34) ? SUM_A : 34;
  localparam int CWD   = (SUM_B > QW + 1) ? SUM_B : QW + 1;

  typedef logic signed [QW-1:0]  q_t;
  typedef logic signed [QW+1:0]  qx_t;
  typedef logic signed [CWD-1:0] cx_t;
  typedef logic signed [IDX_W:0] off_t;

  localparam qx_t QMAX_X = $signed({3'b000, {(QW-1){1'b1}}});
  localparam qx_t QMIN_X = $signed({3'b111, {(QW-1){1'b0}}});
  localparam cx_t CMAX_X = $signed({{(CWD-QW+1){1'b0}}, {(QW-1){1'b1}}});
  localparam cx_t CMIN_X = $signed({{(CWD-QW+1){1'b1}}, {(QW-1){1'b0}}});
  localparam logic [QW:0] LIMIT = (QW+1)'(4) << FRAC_BITS;

  function automatic q_t sat_q(input qx_t v);
    if (v > QMAX_X) begin
      return QMAX_X[QW-1:0];
    end else if (v < QMIN_X) begin
      return QMIN_X[QW-1:0];
    end
    return v[QW-1:0];
  endfunction

  function automatic q_t sat_c(input cx_t v);
    if (v > CMAX_X) begin
      return CMAX_X[QW-1:0];
    end else if (v < CMIN_X) begin
      return CMIN_X[QW-1:0];
    end
    return v[QW-1:0];
  endfunction

  function automatic cx_t scale_off(input off_t off, input logic [mbet_pkg::ZOOM_W-1:0] zoom);
    cx_t            off_x;
    logic [SHW-1:0] zx;
    logic [SHW-1:0] fb;
    off_x = cx_t'(off);
    zx    = SHW'(zoom);
    fb    = SHW'(FRAC_BITS);
    if (zx <= fb) begin
      return off_x <<< (fb - zx);
    end
    return off_x >>> (zx - fb);
  endfunction

  mbet_pkg::state_e state_q, state_d;
  mbet_pkg::sel_e   sel_q, sel_d;

  logic signed [mbet_pkg::COORD_W-1:0] center_real_q;
  logic signed [mbet_pkg::COORD_W-1:0] center_imag_q;
  logic [mbet_pkg::ZOOM_W-1:0]         zoom_q;

  logic [IDX_W-1:0] col_q, row_q;
  q_t               cr_q, ci_q, zr_q, zi_q, rr_q, ii_q, ri_q;
  q_t               cr_d, ci_d, zr_d, zi_d, rr_d, ii_d, ri_d;
  logic [CNT_W-1:0] iter_q, iter_d;
  logic [CNT_W-1:0] fin_cnt_q, fin_cnt_d;
  logic             res_valid_q, res_valid_d;
  logic [CNT_W-1:0] res_cnt_q;
  logic             res_in_set_q;
  logic             res_load;

  logic             pix_req;
  logic             mul_start;
  logic             mul_done;
  q_t               mul_a, mul_b, mul_p;
  off_t             col_off, row_off;
  logic [QW:0]      mag;

  assign pix_req = pixel_i.valid && pixel_i.ready;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_real_q <= '0;
      center_imag_q <= '0;
      zoom_q        <= mbet_pkg::DEF_ZOOM_SHIFT;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mbet_pkg::REG_CENTER_REAL: center_real_q <= $signed(cfg_i.data);
        mbet_pkg::REG_CENTER_IMAG: center_imag_q <= $signed(cfg_i.data);
        mbet_pkg::REG_ZOOM_SHIFT:  zoom_q <= cfg_i.data[mbet_pkg::ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  mbet_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_comb begin
    case (sel_q)
      mbet_pkg::SEL_RI: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      mbet_pkg::SEL_RR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      default: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
    endcase
  end

  assign col_off = off_t'({1'b0, col_q}) - off_t'(HALF);
  assign row_off = off_t'(HALF) - off_t'({1'b0, row_q});
  assign mag     = {1'b0, rr_q} + {1'b0, ii_q};

  // sequencer
  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    cr_d      = cr_q;
    ci_d      = ci_q;
    zr_d      = zr_q;
    zi_d      = zi_q;
    rr_d      = rr_q;
    ii_d      = ii_q;
    ri_d      = ri_q;
    iter_d    = iter_q;
    fin_cnt_d = fin_cnt_q;
    mul_start = 1'b0;
    res_load  = 1'b0;
    case (state_q)
      mbet_pkg::ST_IDLE: begin
        if (pix_req) begin
          state_d = mbet_pkg::ST_INIT;
        end
      end
      mbet_pkg::ST_INIT: begin
        cr_d   = sat_c(cx_t'(sat_c(cx_t'(center_real_q))) + scale_off(col_off, zoom_q));
        ci_d   = sat_c(cx_t'(sat_c(cx_t'(center_imag_q))) + scale_off(row_off, zoom_q));
        zr_d   = '0;
        zi_d   = '0;
        rr_d   = '0;
        ii_d   = '0;
        iter_d = CNT_W'(1);
        sel_d  = mbet_pkg::SEL_RI;
        if (MAX_ITER <= 1) begin
          fin_cnt_d = CNT_W'(MAX_ITER);
          state_d   = mbet_pkg::ST_DONE;
        end else begin
          state_d = mbet_pkg::ST_MUL_GO;
        end
      end
      mbet_pkg::ST_MUL_GO: begin
        mul_start = 1'b1;
        state_d   = mbet_pkg::ST_MUL_WAIT;
      end
      mbet_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          case (sel_q)
            mbet_pkg::SEL_RI: begin
              ri_d    = mul_p;
              state_d = mbet_pkg::ST_UPDATE;
            end
            mbet_pkg::SEL_RR: begin
              rr_d    = mul_p;
              sel_d   = mbet_pkg::SEL_II;
              state_d = mbet_pkg::ST_MUL_GO;
            end
            default: begin
              ii_d    = mul_p;
              state_d = mbet_pkg::ST_CHECK;
            end
          endcase
        end
      end
      mbet_pkg::ST_UPDATE: begin
        zr_d    = sat_q(qx_t'(sat_q(qx_t'(rr_q) - qx_t'(ii_q))) + qx_t'(cr_q));
        zi_d    = sat_q(qx_t'(sat_q(qx_t'(ri_q) <<< 1)) + qx_t'(ci_q));
        sel_d   = mbet_pkg::SEL_RR;
        state_d = mbet_pkg::ST_MUL_GO;
      end
      mbet_pkg::ST_CHECK: begin
        if (mag > LIMIT) begin
          fin_cnt_d = iter_q;
          state_d   = mbet_pkg::ST_DONE;
        end else if (iter_q == CNT_W'(MAX_ITER - 1)) begin
          fin_cnt_d = CNT_W'(MAX_ITER);
          state_d   = mbet_pkg::ST_DONE;
        end else begin
          iter_d  = iter_q + CNT_W'(1);
          sel_d   = mbet_pkg::SEL_RI;
          state_d = mbet_pkg::ST_MUL_GO;
        end
      end
      mbet_pkg::ST_DONE: begin
        if (!res_valid_q || result_o.ready) begin
          res_load = 1'b1;
          state_d  = mbet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mbet_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbet_pkg::ST_IDLE;
      sel_q       <= mbet_pkg::SEL_RI;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_req) begin
      col_q <= pixel_i.col_index;
      row_q <= pixel_i.row_index;
    end
    cr_q      <= cr_d;
    ci_q      <= ci_d;
    zr_q      <= zr_d;
    zi_q      <= zi_d;
    rr_q      <= rr_d;
    ii_q      <= ii_d;
    ri_q      <= ri_d;
    iter_q    <= iter_d;
    fin_cnt_q <= fin_cnt_d;
    if (res_load) begin
      res_cnt_q    <= fin_cnt_q;
      res_in_set_q <= (fin_cnt_q == CNT_W'(MAX_ITER));
    end
  end

  assign pixel_i.ready         = (state_q == mbet_pkg::ST_IDLE);
  assign result_o.valid        = res_valid_q;
  assign result_o.escape_count = mbet_pkg::COUNT_W'(res_cnt_q);
  assign result_o.in_set       = res_in_set_q;

  // checks
  a_mul_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == mbet_pkg::ST_MUL_WAIT))
    else $error("multiplier result outside a wait step");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbet_pkg::ST_CHECK) |-> (iter_q != '0 && iter_q <= CNT_W'(MAX_ITER - 1)))
    else $error("iteration counter out of range");

  a_in_set_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_in_set_q == (res_cnt_q == CNT_W'(MAX_ITER))))
    else $error("in-set flag disagrees with escape count");

  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |=> !mul_done)
    else $error("multiplier finished too early");

endmodule
